// ----- design/smam_pkg.sv -----
package smam_pkg;

	localparam int VALUE_W    = 32;
	localparam int PORT_IDX_W = 16;
	localparam int FUNC_W     = 2;

	localparam logic [FUNC_W-1:0] FUNC_LOAD_A = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_B = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RUN    = 2'd2;

	localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
	localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

endpackage

// ----- design/sparse_matrix_add_sub_merge_core.sv -----
// channel  | valid / ready          | payload
// ---------+------------------------+--------------------------------------------
// in       | in_valid / in_ready    | func, entry_row, entry_column, entry_value
// out      | out_valid / out_ready  | out_row, out_column, out_value, is_entry,
//          |                        | last, saturated, load_dropped
// cfg      | cfg_valid / cfg_ready  | subtract_mode
//
// Loads and unused codes are accepted back to back.
// Each merge step of a run is a memory read (S_FETCH), then a compare and combine
// (S_MERGE); the single read port of each entry memory sets that order.
// One finished result is held back to mark last.
// in_ready is low for the whole run; out_ready low stalls the merge only when a
// finished result has to move into a full output register.
// Reset clears counts, drop flag and mode; the entry memories are not cleared.
module sparse_matrix_add_sub_merge_core #(
	parameter int ENTRY_DEPTH = 32,
	parameter int INDEX_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [smam_pkg::FUNC_W-1:0]          func,
	input  logic [smam_pkg::PORT_IDX_W-1:0]      entry_row,
	input  logic [smam_pkg::PORT_IDX_W-1:0]      entry_column,
	input  logic signed [smam_pkg::VALUE_W-1:0]  entry_value,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [smam_pkg::PORT_IDX_W-1:0]      out_row,
	output logic [smam_pkg::PORT_IDX_W-1:0]      out_column,
	output logic signed [smam_pkg::VALUE_W-1:0]  out_value,
	output logic                                 is_entry,
	output logic                                 last,
	output logic                                 saturated,
	output logic                                 load_dropped,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic                                 subtract_mode
);

	localparam int PW    = smam_pkg::PORT_IDX_W;
	localparam int VW    = smam_pkg::VALUE_W;
	localparam int IDX_W = (INDEX_BITS < PW) ? INDEX_BITS : PW;
	localparam int KEY_W = 2 * IDX_W;
	localparam int ENT_W = KEY_W + VW;
	localparam int AW    = (ENTRY_DEPTH > 1) ? $clog2(ENTRY_DEPTH) : 1;
	localparam int CW    = $clog2(ENTRY_DEPTH + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_FETCH = 2'd1;
	localparam logic [1:0] S_MERGE = 2'd2;

	logic [1:0]       state_q;
	logic             sub_q;
	logic [CW-1:0]    a_cnt_q, b_cnt_q, a_ptr_q, b_ptr_q;
	logic             drop_q;

	logic [ENT_W-1:0] a_mem [ENTRY_DEPTH];
	logic [ENT_W-1:0] b_mem [ENTRY_DEPTH];
	logic [ENT_W-1:0] a_rd_s1, b_rd_s1;

	logic             pend_valid_q;
	logic [KEY_W-1:0] pend_key_q;
	logic [VW-1:0]    pend_val_q;
	logic             pend_sat_q;
	logic             out_valid_q;

	logic             in_fire, load_a, load_b, run;
	logic [KEY_W-1:0] in_key, a_key, b_key, res_key;
	logic [VW-1:0]    a_val, b_val, opx, opy, res_val;
	logic [VW:0]      sum;
	logic             a_has, b_has, take_a, take_b, res_sat, emit;
	logic             out_free, done, stall, push, push_last, push_marker, adv;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign in_fire   = in_valid && in_ready;
	assign load_a    = in_fire && (func == smam_pkg::FUNC_LOAD_A);
	assign load_b    = in_fire && (func == smam_pkg::FUNC_LOAD_B);
	assign run       = in_fire && (func == smam_pkg::FUNC_RUN);
	assign in_key    = {entry_row[IDX_W-1:0], entry_column[IDX_W-1:0]};

	always_ff @(posedge clk) begin
		if (load_a && (a_cnt_q < CW'(ENTRY_DEPTH))) begin
			a_mem[a_cnt_q[AW-1:0]] <= {in_key, entry_value};
		end
		a_rd_s1 <= a_mem[a_ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (load_b && (b_cnt_q < CW'(ENTRY_DEPTH))) begin
			b_mem[b_cnt_q[AW-1:0]] <= {in_key, entry_value};
		end
		b_rd_s1 <= b_mem[b_ptr_q[AW-1:0]];
	end

	always_comb begin
		a_key  = a_rd_s1[ENT_W-1:VW];
		a_val  = a_rd_s1[VW-1:0];
		b_key  = b_rd_s1[ENT_W-1:VW];
		b_val  = b_rd_s1[VW-1:0];
		a_has  = a_ptr_q < a_cnt_q;
		b_has  = b_ptr_q < b_cnt_q;
		take_a = !b_has || (a_has && (a_key < b_key));
		take_b = !take_a && (!a_has || (b_key < a_key));
		opx    = take_b ? '0 : a_val;
		opy    = take_a ? '0 : b_val;
		sum    = sub_q ? ({opx[VW-1], opx} - {opy[VW-1], opy})
		               : ({opx[VW-1], opx} + {opy[VW-1], opy});
		res_sat = sum[VW] ^ sum[VW-1];
		res_val = res_sat ? (sum[VW] ? smam_pkg::VALUE_MIN : smam_pkg::VALUE_MAX)
		                  : sum[VW-1:0];
		res_key = take_b ? b_key : a_key;
		// equal keys cancelling to zero are dropped when subtracting
		emit    = !(sub_q && !take_a && !take_b && !res_sat && (sum == '0));

		out_free    = !out_valid_q || out_ready;
		done        = !a_has && !b_has;
		stall       = done ? !out_free : (emit && pend_valid_q && !out_free);
		push        = (state_q == S_MERGE) && !stall && (done || (emit && pend_valid_q));
		push_last   = done;
		push_marker = done && !pend_valid_q;
		adv         = (state_q == S_MERGE) && !stall && !done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			sub_q        <= 1'b0;
			a_cnt_q      <= '0;
			b_cnt_q      <= '0;
			a_ptr_q      <= '0;
			b_ptr_q      <= '0;
			drop_q       <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				sub_q <= subtract_mode;
			end
			if (push) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (load_a) begin
						if (a_cnt_q < CW'(ENTRY_DEPTH)) begin
							a_cnt_q <= a_cnt_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
					end
					if (load_b) begin
						if (b_cnt_q < CW'(ENTRY_DEPTH)) begin
							b_cnt_q <= b_cnt_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
					end
					if (run) begin
						a_ptr_q      <= '0;
						b_ptr_q      <= '0;
						pend_valid_q <= 1'b0;
						state_q      <= S_FETCH;
					end
				end
				S_FETCH: begin
					state_q <= S_MERGE;
				end
				S_MERGE: begin
					if (adv) begin
						if (take_a || !take_b) begin
							a_ptr_q <= a_ptr_q + 1'b1;
						end
						if (!take_a) begin
							b_ptr_q <= b_ptr_q + 1'b1;
						end
						if (emit) begin
							pend_valid_q <= 1'b1;
						end
						state_q <= S_FETCH;
					end else if (push && push_last) begin
						a_cnt_q      <= '0;
						b_cnt_q      <= '0;
						drop_q       <= 1'b0;
						pend_valid_q <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			pend_key_q <= res_key;
			pend_val_q <= res_val;
			pend_sat_q <= res_sat;
		end
		if (push) begin
			out_row      <= push_marker ? '0 : PW'(pend_key_q[KEY_W-1:IDX_W]);
			out_column   <= push_marker ? '0 : PW'(pend_key_q[IDX_W-1:0]);
			out_value    <= push_marker ? '0 : pend_val_q;
			saturated    <= push_marker ? 1'b0 : pend_sat_q;
			is_entry     <= !push_marker;
			last         <= push_last;
			load_dropped <= drop_q;
		end
	end

endmodule

// ----- design/smam_checker.sv -----
module smam_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [smam_pkg::FUNC_W-1:0]         func,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [smam_pkg::PORT_IDX_W-1:0]     out_row,
	input logic signed [smam_pkg::VALUE_W-1:0] out_value,
	input logic                                is_entry,
	input logic                                last,
	input logic                                saturated
);

	// a run keeps the input closed at least for the next cycle
	a_run_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (func == smam_pkg::FUNC_RUN) |=> !in_ready)
		else $error("input open right after a run item");

	a_marker_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_entry |-> last && !saturated && (out_value == '0))
		else $error("empty marker malformed");

	a_sat_limit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
			(out_value == smam_pkg::VALUE_MAX) || (out_value == smam_pkg::VALUE_MIN))
		else $error("saturated item not at a limit");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_row)
			&& $stable(last))
		else $error("stalled result item changed");

endmodule

bind sparse_matrix_add_sub_merge_core smam_checker u_smam_checker (.*);

// ----- bench/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STORE_DEPTH = 32;
	localparam int DRAIN_CYCLES = 20;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [smam_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [smam_pkg::PORT_IDX_W-1:0] row;
		logic [smam_pkg::PORT_IDX_W-1:0] col;
		logic signed [smam_pkg::VALUE_W-1:0] value;
		logic is_entry;
		logic last;
		logic sat;
		logic dropped;
	} merged_entry_t;

	class merge_scoreboard;
		bit sub_mode;
		logic [31:0] a_keys[STORE_DEPTH];
		logic [31:0] b_keys[STORE_DEPTH];
		logic signed [smam_pkg::VALUE_W-1:0] a_vals[STORE_DEPTH];
		logic signed [smam_pkg::VALUE_W-1:0] b_vals[STORE_DEPTH];
		int a_cnt;
		int b_cnt;
		bit dropped;
		merged_entry_t expected_q[$];
		int errors;

		function void set_mode(bit m);
			sub_mode = m;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic signed [smam_pkg::VALUE_W-1:0] saturate(longint x, output bit sat);
			sat = 1'b0;
			if (x > longint'($signed(smam_pkg::VALUE_MAX))) begin
				sat = 1'b1;
				return smam_pkg::VALUE_MAX;
			end
			if (x < longint'($signed(smam_pkg::VALUE_MIN))) begin
				sat = 1'b1;
				return smam_pkg::VALUE_MIN;
			end
			return x[smam_pkg::VALUE_W-1:0];
		endfunction

		function merged_entry_t make_entry(logic [31:0] key,
				logic signed [smam_pkg::VALUE_W-1:0] v, bit sat);
			merged_entry_t e;
			e.row = key[31:16];
			e.col = key[15:0];
			e.value = v;
			e.is_entry = 1'b1;
			e.last = 1'b0;
			e.sat = sat;
			e.dropped = dropped;
			return e;
		endfunction

		function void note_input(logic [smam_pkg::FUNC_W-1:0] f,
				logic [smam_pkg::PORT_IDX_W-1:0] r, logic [smam_pkg::PORT_IDX_W-1:0] c,
				logic signed [smam_pkg::VALUE_W-1:0] v);
			merged_entry_t run_q[$];
			merged_entry_t marker;
			logic signed [smam_pkg::VALUE_W-1:0] res;
			longint sum;
			bit sat;
			int i;
			int j;
			i = 0;
			j = 0;
			if (f == smam_pkg::FUNC_LOAD_A) begin
				if (a_cnt < STORE_DEPTH) begin
					a_keys[a_cnt] = {r, c};
					a_vals[a_cnt] = v;
					a_cnt++;
				end else
					dropped = 1'b1;
				return;
			end
			if (f == smam_pkg::FUNC_LOAD_B) begin
				if (b_cnt < STORE_DEPTH) begin
					b_keys[b_cnt] = {r, c};
					b_vals[b_cnt] = v;
					b_cnt++;
				end else
					dropped = 1'b1;
				return;
			end
			if (f != smam_pkg::FUNC_RUN)
				return;
			while (i < a_cnt || j < b_cnt) begin
				if (j >= b_cnt || (i < a_cnt && a_keys[i] < b_keys[j])) begin
					run_q = {run_q, make_entry(a_keys[i], a_vals[i], 1'b0)};
					i++;
				end else if (i >= a_cnt || b_keys[j] < a_keys[i]) begin
					sum = sub_mode ? -longint'(b_vals[j]) : longint'(b_vals[j]);
					res = saturate(sum, sat);
					run_q = {run_q, make_entry(b_keys[j], res, sat)};
					j++;
				end else begin
					sum = sub_mode ? longint'(a_vals[i]) - longint'(b_vals[j])
						: longint'(a_vals[i]) + longint'(b_vals[j]);
					res = saturate(sum, sat);
					if (!sub_mode || res != 0)
						run_q = {run_q, make_entry(a_keys[i], res, sat)};
					i++;
					j++;
				end
			end
			if (run_q.size() == 0) begin
				marker = '0;
				marker.last = 1'b1;
				marker.dropped = dropped;
				run_q = {run_q, marker};
			end else
				run_q[run_q.size()-1].last = 1'b1;
			foreach (run_q[k])
				expected_q = {expected_q, run_q[k]};
			a_cnt = 0;
			b_cnt = 0;
			dropped = 1'b0;
		endfunction

		function void check_result(merged_entry_t got);
			merged_entry_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: unexpected result, actual %p", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got !== want) begin
				$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [smam_pkg::FUNC_W-1:0] func = '0;
	logic [smam_pkg::PORT_IDX_W-1:0] entry_row = '0;
	logic [smam_pkg::PORT_IDX_W-1:0] entry_column = '0;
	logic signed [smam_pkg::VALUE_W-1:0] entry_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [smam_pkg::PORT_IDX_W-1:0] out_row;
	logic [smam_pkg::PORT_IDX_W-1:0] out_column;
	logic signed [smam_pkg::VALUE_W-1:0] out_value;
	logic is_entry;
	logic last;
	logic saturated;
	logic load_dropped;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic subtract_mode = 1'b0;

	merge_scoreboard sb = new();
	merged_entry_t seen;
	int idle_pct = 0;
	int stall_pct = 0;
	int hold_cycles = 0;
	int items_sent = 0;
	int cycles = 0;

	sparse_matrix_add_sub_merge_core dut (.*);

	always #5ns clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("testbench: FAIL");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 1'b0;
		end else
			out_ready <= ($urandom_range(0, 99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			seen = '{out_row, out_column, out_value, is_entry, last, saturated, load_dropped};
			sb.check_result(seen);
		end
	end

	task automatic send_item(logic [smam_pkg::FUNC_W-1:0] f,
			logic [smam_pkg::PORT_IDX_W-1:0] r, logic [smam_pkg::PORT_IDX_W-1:0] c,
			logic signed [smam_pkg::VALUE_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		entry_row <= r;
		entry_column <= c;
		entry_value <= v;
		do @(posedge clk); while (!in_ready);
		sb.note_input(f, r, c, v);
		if (f != FUNC_UNUSED)
			items_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic start_phase(int in_idle, int out_stall, int hold, bit mode);
		wait_drain();
		cfg_valid <= 1'b1;
		subtract_mode <= mode;
		do @(posedge clk); while (!cfg_ready);
		sb.set_mode(mode);
		@(negedge clk);
		cfg_valid <= 1'b0;
		idle_pct = in_idle;
		stall_pct = out_stall;
		if (hold > 0) begin
			@(posedge clk);
			hold_cycles = hold;
		end
	endtask

	function automatic logic signed [smam_pkg::VALUE_W-1:0] rand_value();
		case ($urandom_range(0, 7))
			0: return smam_pkg::VALUE_MAX;
			1: return smam_pkg::VALUE_MIN;
			2: return int'($urandom_range(0, 6)) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic run_merge();
		send_item(smam_pkg::FUNC_RUN, 16'($urandom), 16'($urandom), $urandom);
	endtask

	// one matrix pair: loads for A and B interleaved, then a run
	task automatic merge_sequence();
		logic [31:0] a_k[$];
		logic [31:0] b_k[$];
		logic signed [smam_pkg::VALUE_W-1:0] a_v[$];
		logic signed [smam_pkg::VALUE_W-1:0] b_v[$];
		logic [31:0] key;
		logic [31:0] tk;
		logic signed [smam_pkg::VALUE_W-1:0] va;
		logic signed [smam_pkg::VALUE_W-1:0] vb;
		logic signed [smam_pkg::VALUE_W-1:0] tv;
		bit big;
		int kind;
		int n;
		int pick;
		int p;
		int q;
		big = ($urandom_range(0, 9) == 0);
		kind = (big && $urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 9);
		n = big ? $urandom_range(30, 36) : $urandom_range(0, 8);
		key = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
			: $urandom_range(0, 32'hF000_0000);
		for (int k = 0; k < n; k++) begin
			pick = (kind == 0) ? 2 : $urandom_range(0, 2);
			va = rand_value();
			case ($urandom_range(0, 3))
				0: vb = va;
				1: vb = -va;
				default: vb = rand_value();
			endcase
			if (kind == 0)
				vb = va;
			if (pick != 1) begin
				a_k = {a_k, key};
				a_v = {a_v, va};
			end
			if (pick != 0) begin
				b_k = {b_k, key};
				b_v = {b_v, vb};
			end
			key += $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, 32'h40_0000);
		end
		// out of order and repeated keys
		if (kind == 1) begin
			if (a_k.size() > 1) begin
				p = $urandom_range(0, a_k.size() - 1);
				q = $urandom_range(0, a_k.size() - 1);
				tk = a_k[p];
				a_k[p] = a_k[q];
				a_k[q] = tk;
				tv = a_v[p];
				a_v[p] = a_v[q];
				a_v[q] = tv;
			end
			if (b_k.size() > 0) begin
				b_k = {b_k, b_k[0]};
				b_v = {b_v, rand_value()};
			end
		end
		while (a_k.size() != 0 || b_k.size() != 0) begin
			if ($urandom_range(0, 11) == 0)
				send_item(FUNC_UNUSED, 16'($urandom), 16'($urandom), $urandom);
			if (b_k.size() == 0 || (a_k.size() != 0 && $urandom_range(0, 1))) begin
				tk = a_k.pop_front();
				send_item(smam_pkg::FUNC_LOAD_A, tk[31:16], tk[15:0], a_v.pop_front());
			end else begin
				tk = b_k.pop_front();
				send_item(smam_pkg::FUNC_LOAD_B, tk[31:16], tk[15:0], b_v.pop_front());
			end
		end
		run_merge();
	endtask

	task automatic random_items(int target);
		int start;
		start = items_sent;
		while (items_sent - start < target)
			merge_sequence();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		start_phase(0, 0, 0, 1'b0);
		run_merge();
		send_item(FUNC_UNUSED, 16'hFFFF, 16'hFFFF, smam_pkg::VALUE_MIN);
		send_item(smam_pkg::FUNC_LOAD_A, 16'h0000, 16'h0000, smam_pkg::VALUE_MAX);
		send_item(smam_pkg::FUNC_LOAD_B, 16'h0000, 16'h0000, 32'sd1);
		send_item(smam_pkg::FUNC_LOAD_A, 16'h0000, 16'h0005, smam_pkg::VALUE_MIN);
		send_item(smam_pkg::FUNC_LOAD_B, 16'h0000, 16'h0005, -32'sd1);
		send_item(smam_pkg::FUNC_LOAD_A, 16'h0001, 16'h0001, 32'sd3);
		send_item(smam_pkg::FUNC_LOAD_B, 16'h0001, 16'h0001, -32'sd3);
		send_item(smam_pkg::FUNC_LOAD_B, 16'hFFFF, 16'h0000, 32'sd7);
		send_item(smam_pkg::FUNC_LOAD_A, 16'hFFFF, 16'hFFFF, -32'sd5);
		run_merge();
		random_items(40);

		start_phase(0, 0, 0, 1'b1);
		send_item(smam_pkg::FUNC_LOAD_A, 16'h0002, 16'h0002, 32'sd10);
		send_item(smam_pkg::FUNC_LOAD_B, 16'h0002, 16'h0002, 32'sd10);
		send_item(smam_pkg::FUNC_LOAD_B, 16'h0003, 16'h0003, smam_pkg::VALUE_MIN);
		send_item(smam_pkg::FUNC_LOAD_A, 16'h0004, 16'h0004, smam_pkg::VALUE_MIN);
		send_item(smam_pkg::FUNC_LOAD_B, 16'h0004, 16'h0004, 32'sd1);
		run_merge();
		send_item(smam_pkg::FUNC_LOAD_A, 16'h0007, 16'h0007, 32'sd5);
		send_item(smam_pkg::FUNC_LOAD_B, 16'h0007, 16'h0007, 32'sd5);
		run_merge();
		random_items(40);

		start_phase(88, 0, 0, 1'b0);
		random_items(40);
		start_phase(0, 88, 0, 1'b1);
		random_items(40);
		start_phase(15, 15, 0, 1'b0);
		random_items(40);
		start_phase(0, 0, 500, 1'b1);
		random_items(40);

		wait_drain();
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end

endmodule
